@@ hdl/ima_dec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_dec_pkg
// Shared types, constants and tables of the IMA ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package ima_dec_pkg;

  localparam int SampleW = 16;
  localparam int IdxW    = 7;
  localparam int StepW   = 15;
  localparam int DiffW   = StepW + 2;
  localparam int SumW    = SampleW + 2;
  localparam int AdjW    = 5;

  localparam logic [IdxW-1:0]           IdxMax    = IdxW'(88);
  localparam logic signed [SumW-1:0]    SampleMax = SumW'(32767);
  localparam logic signed [SumW-1:0]    SampleMin = -SumW'(32768);

  // Decoder state carried from one code to the next.
  typedef struct packed {
    logic signed [SampleW-1:0] pred;
    logic [IdxW-1:0]           idx;
  } ima_dec_state_t;

  function automatic logic [StepW-1:0] step_lut(input logic [IdxW-1:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [AdjW-1:0] idx_adjust(input logic [2:0] mag);
    logic signed [AdjW-1:0] a;
    case (mag)
      3'd4:    a = AdjW'(2);
      3'd5:    a = AdjW'(4);
      3'd6:    a = AdjW'(6);
      3'd7:    a = AdjW'(8);
      default: a = -AdjW'(1);
    endcase
    return a;
  endfunction

endpackage

@@ hdl/ima_dec_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_dec_if
// Valid/ready channels of the decoder: packed code bytes in, samples out.
// ----------------------------------------------------------------------------
interface ima_dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_codes;
  logic       restart;
  logic       final_byte;

  modport source (output valid, output packed_codes, output restart,
                  output final_byte, input ready);
  modport sink   (input valid, input packed_codes, input restart,
                  input final_byte, output ready);
endinterface

interface ima_dec_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ima_dec_pkg::SampleW-1:0] sample;
  logic                                 second_of_pair;
  logic                                 buffer_end;

  modport source (output valid, output sample, output second_of_pair,
                  output buffer_end, input ready);
  modport sink   (input valid, input sample, input second_of_pair,
                  input buffer_end, output ready);
endinterface

@@ hdl/ima_dec_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_dec_step
// One IMA ADPCM code: step lookup, difference, saturating predictor update
// and clamped step index update.
// ----------------------------------------------------------------------------
module ima_dec_step (
  input  ima_dec_pkg::ima_dec_state_t st_in,
  input  logic [3:0]                  code,
  output ima_dec_pkg::ima_dec_state_t st_out
);

  logic [ima_dec_pkg::IdxW-1:0]         idx_c;
  logic [ima_dec_pkg::StepW-1:0]        step;
  logic [ima_dec_pkg::DiffW-1:0]        diff;
  logic signed [ima_dec_pkg::SumW-1:0]  pred_ext;
  logic signed [ima_dec_pkg::SumW-1:0]  diff_ext;
  logic signed [ima_dec_pkg::SumW-1:0]  sum;
  logic signed [ima_dec_pkg::AdjW-1:0]  adj;
  logic signed [ima_dec_pkg::IdxW:0]    idx_sum;

  always_comb begin
    idx_c = (st_in.idx > ima_dec_pkg::IdxMax) ? ima_dec_pkg::IdxMax : st_in.idx;
    step  = ima_dec_pkg::step_lut(idx_c);

    diff = ima_dec_pkg::DiffW'(step >> 3);
    if (code[2]) begin
      diff = diff + ima_dec_pkg::DiffW'(step);
    end
    if (code[1]) begin
      diff = diff + ima_dec_pkg::DiffW'(step >> 1);
    end
    if (code[0]) begin
      diff = diff + ima_dec_pkg::DiffW'(step >> 2);
    end

    pred_ext = ima_dec_pkg::SumW'(st_in.pred);
    diff_ext = $signed({1'b0, diff});
    sum      = code[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

    if (sum > ima_dec_pkg::SampleMax) begin
      st_out.pred = ima_dec_pkg::SampleW'(ima_dec_pkg::SampleMax);
    end else if (sum < ima_dec_pkg::SampleMin) begin
      st_out.pred = ima_dec_pkg::SampleW'(ima_dec_pkg::SampleMin);
    end else begin
      st_out.pred = sum[ima_dec_pkg::SampleW-1:0];
    end

    adj     = ima_dec_pkg::idx_adjust(code[2:0]);
    idx_sum = $signed({1'b0, idx_c}) +
              $signed({{(ima_dec_pkg::IdxW + 1 - ima_dec_pkg::AdjW){adj[ima_dec_pkg::AdjW-1]}},
                       adj});
    if (idx_sum[ima_dec_pkg::IdxW]) begin
      st_out.idx = '0;
    end else if (idx_sum[ima_dec_pkg::IdxW-1:0] > ima_dec_pkg::IdxMax) begin
      st_out.idx = ima_dec_pkg::IdxMax;
    end else begin
      st_out.idx = idx_sum[ima_dec_pkg::IdxW-1:0];
    end
  end

endmodule

@@ hdl/ima_adpcm_nibble_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder_top
// IMA ADPCM decoder: one byte of two 4-bit codes in, two 16-bit samples out.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  in_ch   | in  | packed_codes[7:0], restart, final_byte
//  out_ch  | out | sample[15:0] signed, second_of_pair, buffer_end
//
//  A byte sits in an input register and is decoded one nibble per cycle,
//  high nibble first, while the output is not stalled, into an output
//  register by the single shared decode step. The next byte is taken in
//  the cycle its predecessor's low nibble is decoded. A stalled output
//  holds both the output register and the byte in progress. Synchronous
//  reset clears the predictor, the step index and all valid flags.
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  ima_dec_in_if.sink           in_ch,
  ima_dec_out_if.source        out_ch
);

  logic       hold_v_r, hold_v_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] codes_r, codes_nxt;
  logic       restart_r, restart_nxt;
  logic       final_r, final_nxt;

  ima_dec_pkg::ima_dec_state_t st_r, st_nxt, st_cur, st_step;

  logic                                   out_v_r, out_v_nxt;
  logic signed [ima_dec_pkg::SampleW-1:0] sample_r, sample_nxt;
  logic                                   second_r, second_nxt;
  logic                                   end_r, end_nxt;

  logic       fire;
  logic       in_take;
  logic [3:0] code;

  assign fire    = hold_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !hold_v_r || (fire && phase_r);
  assign in_take = in_ch.valid && in_ch.ready;

  assign code = phase_r ? codes_r[3:0] : codes_r[7:4];

  // Restart zeroes the state ahead of the high nibble only.
  always_comb begin
    st_cur = st_r;
    if (!phase_r && restart_r) begin
      st_cur = '0;
    end
  end

  ima_dec_step u_step (
    .st_in  (st_cur),
    .code   (code),
    .st_out (st_step)
  );

  always_comb begin
    hold_v_nxt  = hold_v_r;
    phase_nxt   = phase_r;
    codes_nxt   = codes_r;
    restart_nxt = restart_r;
    final_nxt   = final_r;
    st_nxt      = st_r;
    if (fire) begin
      st_nxt    = st_step;
      phase_nxt = !phase_r;
      if (phase_r) begin
        hold_v_nxt = 1'b0;
      end
    end
    if (in_take) begin
      hold_v_nxt  = 1'b1;
      phase_nxt   = 1'b0;
      codes_nxt   = in_ch.packed_codes;
      restart_nxt = in_ch.restart;
      final_nxt   = in_ch.final_byte;
    end
  end

  always_comb begin
    out_v_nxt  = out_v_r;
    sample_nxt = sample_r;
    second_nxt = second_r;
    end_nxt    = end_r;
    if (fire) begin
      out_v_nxt  = 1'b1;
      sample_nxt = st_step.pred;
      second_nxt = phase_r;
      end_nxt    = phase_r && final_r;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      phase_r  <= 1'b0;
      out_v_r  <= 1'b0;
      st_r     <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      phase_r  <= phase_nxt;
      out_v_r  <= out_v_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    codes_r   <= codes_nxt;
    restart_r <= restart_nxt;
    final_r   <= final_nxt;
    sample_r  <= sample_nxt;
    second_r  <= second_nxt;
    end_r     <= end_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.sample         = sample_r;
  assign out_ch.second_of_pair = second_r;
  assign out_ch.buffer_end     = end_r;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.idx <= ima_dec_pkg::IdxMax)
    else $error("step index left its range");

  a_no_take_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (!hold_v_r || phase_r))
    else $error("byte taken before high nibble decoded");

  a_phase_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> hold_v_r)
    else $error("low-nibble phase without a held byte");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.second_of_pair)
      |=> (out_ch.valid && out_ch.second_of_pair))
    else $error("low-nibble sample did not follow high-nibble sample");

  a_end_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.buffer_end) |-> out_ch.second_of_pair)
    else $error("buffer end flagged on high-nibble sample");
`endif

endmodule
